// ----- src/degree_ordered_vertex_relabel_macros.svh -----
// Assertion helpers shared by the relabel block.
`ifndef DEGREE_ORDERED_VERTEX_RELABEL_MACROS_SVH
`define DEGREE_ORDERED_VERTEX_RELABEL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DOVR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DOVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dovr_pkg.sv -----
package dovr_pkg;

  localparam int MAX_VERTICES_DEF  = 1024;
  localparam int DIGIT_BUCKETS_DEF = 256;
  localparam int SORT_PASSES_DEF   = 4;

  localparam int CMD_W      = 2;
  localparam int VTX_W      = 10;
  localparam int MODE_W     = 2;
  localparam int VCNT_W     = 11;
  localparam int DEG_W      = 32;
  localparam int DIGIT_W    = 8;
  localparam int DIGIT_VALS = 256;
  localparam int DEG_BYTES  = DEG_W / DIGIT_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 11'd1024;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cmd_t CMD_COUNT   = 2'd0;
  localparam cmd_t CMD_BUILD   = 2'd1;
  localparam cmd_t CMD_RELABEL = 2'd2;

  localparam mode_t MODE_DEST = 2'd0;
  localparam mode_t MODE_SRC  = 2'd1;
  localparam mode_t MODE_BOTH = 2'd2;

  localparam cfg_idx_t CFG_COUNT_MODE   = 1'd0;
  localparam cfg_idx_t CFG_VERTEX_COUNT = 1'd1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_RL_SRC,
    ST_RL_DST,
    ST_RL_CAP,
    ST_INIT,
    ST_BCLR,
    ST_E_ORD,
    ST_E_DEG,
    ST_E_BKT,
    ST_E_UPD,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_LBL_RD,
    ST_LBL_WR,
    ST_DONE
  } state_t;

  typedef logic [DIGIT_W-1:0] digit_tbl_t [DIGIT_VALS];

  // Digit reduced modulo the bucket count, by repeated subtraction at elaboration.
  function automatic digit_tbl_t digit_mod_tbl(input int buckets);
    digit_tbl_t t;
    int r;
    for (int k = 0; k < DIGIT_VALS; k++) begin
      r = k;
      for (int s = 0; s < DIGIT_VALS; s++) begin
        if (r >= buckets) r = r - buckets;
      end
      t[k] = DIGIT_W'(r);
    end
    return t;
  endfunction

endpackage

// ----- src/dovr_in_if.sv -----
interface dovr_in_if;
  logic                       valid;
  logic                       ready;
  logic [dovr_pkg::CMD_W-1:0] command;
  logic [dovr_pkg::VTX_W-1:0] src_vertex;
  logic [dovr_pkg::VTX_W-1:0] dest_vertex;

  modport source (output valid, output command, output src_vertex, output dest_vertex,
                  input ready);
  modport sink (input valid, input command, input src_vertex, input dest_vertex,
                output ready);
endinterface

// ----- src/dovr_out_if.sv -----
interface dovr_out_if;
  logic                       valid;
  logic                       ready;
  logic [dovr_pkg::VTX_W-1:0] new_src;
  logic [dovr_pkg::VTX_W-1:0] new_dest;
  logic                       status;

  modport source (output valid, output new_src, output new_dest, output status,
                  input ready);
  modport sink (input valid, input new_src, input new_dest, input status,
                output ready);
endinterface

// ----- src/dovr_cfg_if.sv -----
interface dovr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dovr_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [dovr_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- src/degree_ordered_vertex_relabel.sv -----
// One request at a time: the sequencer walks the degree, order, bucket and
// label memories through one shared adder, and it takes no new request until
// the result of the last one is loaded into the output register. Results wait
// there; while that register is still full the sequencer holds in its done state.
// Reset (rst_n low, synchronous) starts a pass that zeroes the degree memory;
// no request is taken until it ends.
`include "degree_ordered_vertex_relabel_macros.svh"

module degree_ordered_vertex_relabel #(
  parameter int MAX_VERTICES  = dovr_pkg::MAX_VERTICES_DEF,
  parameter int DIGIT_BUCKETS = dovr_pkg::DIGIT_BUCKETS_DEF,
  parameter int SORT_PASSES   = dovr_pkg::SORT_PASSES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  dovr_in_if.sink      in_ch,
  dovr_out_if.source   out_ch,
  dovr_cfg_if.sink     cfg_ch
);
  import dovr_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int BW    = $clog2(DIGIT_BUCKETS);
  localparam int BCW   = $clog2(DIGIT_BUCKETS + 1);
  localparam int PW    = $clog2(SORT_PASSES + 1);
  localparam int CMP_W = (CNT_W > VCNT_W) ? CNT_W : VCNT_W;
  localparam digit_tbl_t DIGIT_TBL = digit_mod_tbl(DIGIT_BUCKETS);

  state_t             state_r, state_nxt;
  logic [MODE_W-1:0]  count_mode_r, count_mode_nxt;
  logic [VCNT_W-1:0]  vertex_count_r, vertex_count_nxt;
  logic [VTX_W-1:0]   src_r, src_nxt, dst_r, dst_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               second_r, second_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [BCW-1:0]     j_r, j_nxt;
  logic [PW-1:0]      pass_r, pass_nxt;
  logic               cur_sel_r, cur_sel_nxt;
  logic               scat_r, scat_nxt;
  logic [AW-1:0]      v_r, v_nxt;
  logic [BW-1:0]      d_r, d_nxt;
  logic [CNT_W-1:0]   base_r, base_nxt;
  logic [VTX_W-1:0]   res_src_r, res_src_nxt, res_dst_r, res_dst_nxt;
  logic               res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0]   out_src_r, out_src_nxt, out_dst_r, out_dst_nxt;
  logic               out_st_r, out_st_nxt;

  logic               deg_we;
  logic [AW-1:0]      deg_waddr, deg_raddr;
  logic [DEG_W-1:0]   deg_wdata, deg_rdata;
  logic               ord_we_cur, ord_we_nxt;
  logic [AW-1:0]      ord_waddr, ord_wdata, ord_raddr;
  logic [AW-1:0]      orda_rdata, ordb_rdata, cur_rdata;
  logic               bkt_we;
  logic [BW-1:0]      bkt_waddr, bkt_raddr;
  logic [CNT_W-1:0]   bkt_wdata, bkt_rdata;
  logic               lbl_we;
  logic [AW-1:0]      lbl_waddr, lbl_raddr;
  logic [VTX_W-1:0]   lbl_wdata, lbl_rdata;

  logic [DEG_W-1:0]   alu_a, alu_b;
  logic [DEG_W:0]     alu_sum;
  logic [CMP_W-1:0]   vc_ext;
  logic [CNT_W-1:0]   n_in;
  logic               ok_in;
  logic               last_i;
  logic [1:0]         byte_sel;
  logic [DIGIT_W-1:0] digit_byte;
  logic [BW-1:0]      digit;

  dovr_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata)
  );
  dovr_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_ord_a (
    .clk, .we(cur_sel_r ? ord_we_nxt : ord_we_cur), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(orda_rdata)
  );
  dovr_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_ord_b (
    .clk, .we(cur_sel_r ? ord_we_cur : ord_we_nxt), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ordb_rdata)
  );
  dovr_ram #(.WIDTH(CNT_W), .DEPTH(DIGIT_BUCKETS)) u_bkt (
    .clk, .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
    .raddr(bkt_raddr), .rdata(bkt_rdata)
  );
  dovr_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_lbl (
    .clk, .we(lbl_we), .waddr(lbl_waddr), .wdata(lbl_wdata),
    .raddr(lbl_raddr), .rdata(lbl_rdata)
  );

  assign cur_rdata = cur_sel_r ? ordb_rdata : orda_rdata;

  // Shared adder: degree bump, bucket bump, prefix sum.
  always_comb begin
    case (state_r)
      ST_PFX_WR: begin
        alu_a = DEG_W'(base_r);
        alu_b = DEG_W'(bkt_rdata);
      end
      ST_E_UPD: begin
        alu_a = DEG_W'(bkt_rdata);
        alu_b = DEG_W'(1);
      end
      default: begin
        alu_a = deg_rdata;
        alu_b = DEG_W'(1);
      end
    endcase
  end
  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b};

  assign vc_ext = CMP_W'(vertex_count_r);
  assign n_in   = (vc_ext > CMP_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(vc_ext);
  assign ok_in  = (CMP_W'(in_ch.src_vertex) < CMP_W'(n_in))
               && (CMP_W'(in_ch.dest_vertex) < CMP_W'(n_in));
  assign last_i = (i_r == n_r - CNT_W'(1));

  // Passes beyond the key width see digit zero.
  assign byte_sel   = 2'(pass_r);
  assign digit_byte = (4'(pass_r) < 4'(DEG_BYTES)) ? deg_rdata[{byte_sel, 3'b000} +: DIGIT_W]
                                                   : '0;
  assign digit      = BW'(DIGIT_TBL[digit_byte]);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.new_src  = out_src_r;
  assign out_ch.new_dest = out_dst_r;
  assign out_ch.status   = out_st_r;

  always_comb begin
    state_nxt        = state_r;
    count_mode_nxt   = count_mode_r;
    vertex_count_nxt = vertex_count_r;
    src_nxt          = src_r;
    dst_nxt          = dst_r;
    n_nxt            = n_r;
    addr_nxt         = addr_r;
    second_nxt       = second_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    pass_nxt         = pass_r;
    cur_sel_nxt      = cur_sel_r;
    scat_nxt         = scat_r;
    v_nxt            = v_r;
    d_nxt            = d_r;
    base_nxt         = base_r;
    res_src_nxt      = res_src_r;
    res_dst_nxt      = res_dst_r;
    res_st_nxt       = res_st_r;
    out_valid_nxt    = out_valid_r;
    out_src_nxt      = out_src_r;
    out_dst_nxt      = out_dst_r;
    out_st_nxt       = out_st_r;

    deg_we     = 1'b0;
    deg_waddr  = addr_r;
    deg_wdata  = alu_sum[DEG_W] ? '1 : alu_sum[DEG_W-1:0];
    deg_raddr  = addr_r;
    ord_we_cur = 1'b0;
    ord_we_nxt = 1'b0;
    ord_waddr  = AW'(i_r);
    ord_wdata  = AW'(i_r);
    ord_raddr  = AW'(i_r);
    bkt_we     = 1'b0;
    bkt_waddr  = d_r;
    bkt_wdata  = CNT_W'(alu_sum);
    bkt_raddr  = digit;
    lbl_we     = 1'b0;
    lbl_waddr  = cur_rdata;
    lbl_wdata  = VTX_W'(n_r - CNT_W'(1) - i_r);
    lbl_raddr  = AW'(src_r);

    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_COUNT_MODE:   count_mode_nxt   = cfg_ch.wdata[MODE_W-1:0];
        CFG_VERTEX_COUNT: vertex_count_nxt = cfg_ch.wdata[VCNT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = AW'(i_r);
        deg_wdata = '0;
        if (i_r == CNT_W'(MAX_VERTICES - 1)) begin
          i_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          i_nxt = i_r + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          n_nxt       = n_in;
          src_nxt     = in_ch.src_vertex;
          dst_nxt     = in_ch.dest_vertex;
          res_src_nxt = '0;
          res_dst_nxt = '0;
          res_st_nxt  = 1'b0;
          state_nxt   = ST_DONE;
          case (in_ch.command)
            CMD_COUNT: begin
              if (!ok_in) begin
                res_st_nxt = 1'b1;
              end else begin
                case (count_mode_r)
                  MODE_DEST: begin
                    addr_nxt   = AW'(in_ch.dest_vertex);
                    second_nxt = 1'b0;
                    state_nxt  = ST_CNT_RD;
                  end
                  MODE_SRC: begin
                    addr_nxt   = AW'(in_ch.src_vertex);
                    second_nxt = 1'b0;
                    state_nxt  = ST_CNT_RD;
                  end
                  MODE_BOTH: begin
                    addr_nxt   = AW'(in_ch.dest_vertex);
                    second_nxt = 1'b1;
                    state_nxt  = ST_CNT_RD;
                  end
                  default: ;
                endcase
              end
            end
            CMD_BUILD: begin
              if (n_in != '0) begin
                i_nxt       = '0;
                cur_sel_nxt = 1'b0;
                state_nxt   = ST_INIT;
              end
            end
            CMD_RELABEL: begin
              if (!ok_in) res_st_nxt = 1'b1;
              else state_nxt = ST_RL_SRC;
            end
            default: ;
          endcase
        end
      end
      ST_CNT_RD: begin
        state_nxt = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        deg_we = 1'b1;
        if (second_r) begin
          addr_nxt   = AW'(src_r);
          second_nxt = 1'b0;
          state_nxt  = ST_CNT_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RL_SRC: begin
        state_nxt = ST_RL_DST;
      end
      ST_RL_DST: begin
        lbl_raddr   = AW'(dst_r);
        res_src_nxt = lbl_rdata;
        state_nxt   = ST_RL_CAP;
      end
      ST_RL_CAP: begin
        res_dst_nxt = lbl_rdata;
        state_nxt   = ST_DONE;
      end
      ST_INIT: begin
        ord_we_cur = 1'b1;
        if (last_i) begin
          pass_nxt  = '0;
          j_nxt     = '0;
          state_nxt = ST_BCLR;
        end else begin
          i_nxt = i_r + CNT_W'(1);
        end
      end
      ST_BCLR: begin
        bkt_we    = 1'b1;
        bkt_waddr = BW'(j_r);
        bkt_wdata = '0;
        if (j_r == BCW'(DIGIT_BUCKETS - 1)) begin
          i_nxt     = '0;
          scat_nxt  = 1'b0;
          state_nxt = ST_E_ORD;
        end else begin
          j_nxt = j_r + BCW'(1);
        end
      end
      ST_E_ORD: begin
        state_nxt = ST_E_DEG;
      end
      ST_E_DEG: begin
        deg_raddr = cur_rdata;
        v_nxt     = cur_rdata;
        state_nxt = ST_E_BKT;
      end
      ST_E_BKT: begin
        d_nxt     = digit;
        state_nxt = ST_E_UPD;
      end
      ST_E_UPD: begin
        bkt_we = 1'b1;
        if (scat_r && (bkt_rdata < n_r)) begin
          ord_we_nxt = 1'b1;
          ord_waddr  = AW'(bkt_rdata);
          ord_wdata  = v_r;
        end
        if (!last_i) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = ST_E_ORD;
        end else if (!scat_r) begin
          j_nxt     = '0;
          base_nxt  = '0;
          state_nxt = ST_PFX_RD;
        end else begin
          // Pass done: swap the order buffers.
          cur_sel_nxt = !cur_sel_r;
          pass_nxt    = pass_r + PW'(1);
          i_nxt       = '0;
          j_nxt       = '0;
          if (pass_r == PW'(SORT_PASSES - 1)) state_nxt = ST_LBL_RD;
          else state_nxt = ST_BCLR;
        end
      end
      ST_PFX_RD: begin
        bkt_raddr = BW'(j_r);
        state_nxt = ST_PFX_WR;
      end
      ST_PFX_WR: begin
        bkt_we    = 1'b1;
        bkt_waddr = BW'(j_r);
        bkt_wdata = base_r;
        base_nxt  = CNT_W'(alu_sum);
        if (j_r == BCW'(DIGIT_BUCKETS - 1)) begin
          i_nxt     = '0;
          scat_nxt  = 1'b1;
          state_nxt = ST_E_ORD;
        end else begin
          j_nxt     = j_r + BCW'(1);
          state_nxt = ST_PFX_RD;
        end
      end
      ST_LBL_RD: begin
        state_nxt = ST_LBL_WR;
      end
      ST_LBL_WR: begin
        lbl_we = 1'b1;
        if (last_i) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = ST_LBL_RD;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_src_nxt   = res_src_r;
          out_dst_nxt   = res_dst_r;
          out_st_nxt    = res_st_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      count_mode_r   <= MODE_DEST;
      vertex_count_r <= VCNT_RESET;
      i_r            <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      count_mode_r   <= count_mode_nxt;
      vertex_count_r <= vertex_count_nxt;
      i_r            <= i_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    n_r       <= n_nxt;
    addr_r    <= addr_nxt;
    second_r  <= second_nxt;
    j_r       <= j_nxt;
    pass_r    <= pass_nxt;
    cur_sel_r <= cur_sel_nxt;
    scat_r    <= scat_nxt;
    v_r       <= v_nxt;
    d_r       <= d_nxt;
    base_r    <= base_nxt;
    res_src_r <= res_src_nxt;
    res_dst_r <= res_dst_nxt;
    res_st_r  <= res_st_nxt;
    out_src_r <= out_src_nxt;
    out_dst_r <= out_dst_nxt;
    out_st_r  <= out_st_nxt;
  end

  `DOVR_ASSERT_NEXT(a_accept_leaves_idle, in_ch.valid && in_ch.ready, state_r != ST_IDLE, "request accepted but sequencer stayed idle")
  `DOVR_ASSERT_NOW(a_scatter_in_range, state_r == ST_E_UPD && scat_r, bkt_rdata < n_r, "scatter offset beyond vertex count")
  `DOVR_ASSERT_NOW(a_result_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE, "result loaded outside the done state")

endmodule

// ----- src/dovr_ram.sv -----
module dovr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- bench/dovr_relabel_checker.sv -----
`timescale 1ns / 1ps

module dovr_relabel_checker (
  input  logic clk,
  input  logic rst_n,
  dovr_in_if   in_mon,
  dovr_out_if  out_mon,
  dovr_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);
  import dovr_pkg::*;

  typedef struct packed {
    logic [VTX_W-1:0] new_src;
    logic [VTX_W-1:0] new_dest;
    logic             status;
  } relabel_result_t;

  localparam int NV = MAX_VERTICES_DEF;

  mode_t             count_mode;
  logic [VCNT_W-1:0] vertex_count;
  logic [DEG_W-1:0]  degree_mem [NV];
  logic [VTX_W-1:0]  label_mem [NV];
  relabel_result_t   expected_q [$];

  initial fail_count = 0;

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got_v, exp_v, $time);
    fail_count++;
  endtask

  function automatic int unsigned vertices_in_use();
    return (vertex_count > NV) ? NV : int'(vertex_count);
  endfunction

  function automatic void bump_degree(input int unsigned v);
    if (degree_mem[v] != '1) degree_mem[v] = degree_mem[v] + 1;
  endfunction

  // Stable LSD radix sort by ascending degree, highest degree gets label 0.
  function automatic void rebuild_labels(input int unsigned n);
    int unsigned cur [NV];
    int unsigned nxt [NV];
    int unsigned bucket [DIGIT_VALS];
    int unsigned base, c, d, v;
    for (int i = 0; i < n; i++) cur[i] = i;
    for (int p = 0; p < SORT_PASSES_DEF; p++) begin
      foreach (bucket[b]) bucket[b] = 0;
      for (int i = 0; i < n; i++) begin
        d = (degree_mem[cur[i]] >> (DIGIT_W * p)) & 'hff;
        bucket[d]++;
      end
      base = 0;
      foreach (bucket[b]) begin
        c = bucket[b];
        bucket[b] = base;
        base += c;
      end
      for (int i = 0; i < n; i++) begin
        v = cur[i];
        d = (degree_mem[v] >> (DIGIT_W * p)) & 'hff;
        nxt[bucket[d]] = v;
        bucket[d]++;
      end
      cur = nxt;
    end
    for (int i = 0; i < n; i++) label_mem[cur[i]] = VTX_W'(n - 1 - i);
  endfunction

  function automatic relabel_result_t predict_request(input cmd_t cmd,
                                                      input logic [VTX_W-1:0] s,
                                                      input logic [VTX_W-1:0] d);
    relabel_result_t r;
    int unsigned n;
    logic ok;
    n  = vertices_in_use();
    ok = (s < n) && (d < n);
    r  = '0;
    case (cmd)
      CMD_COUNT: begin
        if (!ok) r.status = 1'b1;
        else if (count_mode == MODE_DEST) bump_degree(d);
        else if (count_mode == MODE_SRC) bump_degree(s);
        else if (count_mode == MODE_BOTH) begin
          bump_degree(d);
          bump_degree(s);
        end
      end
      CMD_BUILD: rebuild_labels(n);
      CMD_RELABEL: begin
        if (!ok) r.status = 1'b1;
        else begin
          r.new_src  = label_mem[s];
          r.new_dest = label_mem[d];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    relabel_result_t got, exp_r;
    if (!rst_n) begin
      count_mode   = MODE_DEST;
      vertex_count = VCNT_RESET;
      foreach (degree_mem[i]) degree_mem[i] = '0;
      expected_q.delete();
    end else begin
      // drain the result before taking a new request in the same edge
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.new_src, out_mon.new_dest, out_mon.status};
        if (expected_q.size() == 0) report_mismatch("unexpected result, status", got.status, 0);
        else begin
          exp_r = expected_q.pop_front();
          if (got.new_src !== exp_r.new_src)
            report_mismatch("new_src", got.new_src, exp_r.new_src);
          if (got.new_dest !== exp_r.new_dest)
            report_mismatch("new_dest", got.new_dest, exp_r.new_dest);
          if (got.status !== exp_r.status)
            report_mismatch("status", got.status, exp_r.status);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.reg_index == CFG_COUNT_MODE) count_mode = mode_t'(cfg_mon.wdata);
        else if (cfg_mon.reg_index == CFG_VERTEX_COUNT) vertex_count = cfg_mon.wdata;
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(predict_request(in_mon.command, in_mon.src_vertex,
                                             in_mon.dest_vertex));
    end
    pending <= expected_q.size();
  end

endmodule

// ----- bench/tb_degree_ordered_vertex_relabel.sv -----
`timescale 1ns / 1ps

module tb_degree_ordered_vertex_relabel;
  import dovr_pkg::*;

  localparam int NV = MAX_VERTICES_DEF;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sent_count;
  int   recv_count;
  bit   quiet;
  int   cur_n;
  bit   label_ok [NV];
  int   stall_left;

  dovr_in_if  in_if ();
  dovr_out_if out_if ();
  dovr_cfg_if cfg_if ();

  degree_ordered_vertex_relabel DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  dovr_relabel_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) recv_count++;
  end

  // Result side back-pressure in random bursts.
  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (quiet) out_if.ready = 1'b1;
      else if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        out_if.ready = 1'b0;
        stall_left   = $urandom_range(1, 15) - 1;
      end else out_if.ready = 1'b1;
    end
  end

  task automatic send_request(input cmd_t cmd, input int s, input int d);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.command     = cmd;
    in_if.src_vertex  = VTX_W'(s);
    in_if.dest_vertex = VTX_W'(d);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_count++;
    if (cmd == CMD_BUILD)
      for (int v = 0; v < cur_n; v++) label_ok[v] = 1'b1;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // Wait until every sent request has returned its result, then idle before going on.
  task automatic settle();
    wait (recv_count == sent_count);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_if.valid     = 1'b1;
    cfg_if.reg_index = idx;
    cfg_if.wdata     = CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == CFG_VERTEX_COUNT) cur_n = (value > NV) ? NV : value;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic int pick_vertex();
    int hot;
    hot = (cur_n < 8) ? cur_n : 8;
    if ($urandom_range(0, 1) == 1) return $urandom_range(0, hot - 1);
    return $urandom_range(0, cur_n - 1);
  endfunction

  // Random command and fields; drop to the unused command rather than read an
  // unwritten label.
  task automatic send_noise();
    cmd_t cmd;
    int s, d;
    s = $urandom_range(0, NV - 1);
    d = $urandom_range(0, NV - 1);
    case ($urandom_range(0, 2))
      0: cmd = CMD_COUNT;
      1: cmd = CMD_RELABEL;
      default: cmd = 2'd3;
    endcase
    if (cmd == CMD_RELABEL && s < cur_n && d < cur_n && !(label_ok[s] && label_ok[d]))
      cmd = 2'd3;
    send_request(cmd, s, d);
  endtask

  task automatic run_phase(input int mode, input int vcount, input int n_items);
    int s, d;
    settle();
    write_reg(CFG_COUNT_MODE, mode);
    write_reg(CFG_VERTEX_COUNT, vcount);
    for (int i = 0; i < n_items / 2; i++) begin
      if ($urandom_range(0, 99) < 85) send_request(CMD_COUNT, pick_vertex(), pick_vertex());
      else send_noise();
    end
    send_request(CMD_BUILD, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
    for (int i = 0; i < n_items / 2; i++) begin
      case ($urandom_range(0, 9))
        0: send_request(CMD_COUNT, pick_vertex(), pick_vertex());
        1: send_noise();
        default: begin
          s = pick_vertex();
          d = pick_vertex();
          send_request(CMD_RELABEL, s, d);
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    sent_count = 0;
    recv_count = 0;
    cur_n = NV;
    foreach (label_ok[v]) label_ok[v] = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_COUNT;
    in_if.src_vertex = '0;
    in_if.dest_vertex = '0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = CFG_COUNT_MODE;
    cfg_if.wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, unused command, zero and oversize vertex counts.
    send_request(CMD_COUNT, 5, 1023);
    send_request(CMD_COUNT, 1023, 1023);
    send_request(CMD_COUNT, 0, 0);
    send_request(2'd3, 1023, 1023);
    settle();
    write_reg(CFG_VERTEX_COUNT, 0);
    send_request(CMD_COUNT, 0, 0);
    send_request(CMD_BUILD, 0, 0);
    send_request(CMD_RELABEL, 0, 0);
    settle();
    write_reg(CFG_COUNT_MODE, 3);
    write_reg(CFG_VERTEX_COUNT, 2047);
    send_request(CMD_COUNT, 1023, 0);
    send_request(CMD_BUILD, 1023, 1023);
    send_request(CMD_RELABEL, 0, 1023);
    send_request(CMD_RELABEL, 1023, 0);
    settle();
    write_reg(CFG_COUNT_MODE, MODE_BOTH);
    write_reg(CFG_VERTEX_COUNT, 1);
    send_request(CMD_COUNT, 0, 0);
    send_request(CMD_COUNT, 0, 1);
    send_request(CMD_RELABEL, 1, 0);
    send_request(CMD_BUILD, 0, 0);
    send_request(CMD_RELABEL, 0, 0);
    settle();
    write_reg(CFG_COUNT_MODE, MODE_SRC);
    write_reg(CFG_VERTEX_COUNT, 1024);
    send_request(CMD_COUNT, 1023, 7);
    send_request(CMD_RELABEL, 1023, 512);

    for (int ph = 0; ph < 14; ph++) begin
      if (ph >= 12) quiet = 1'b1;
      if (ph == 3) run_phase($urandom_range(0, 3), 1024, 110);
      else if (ph == 9) run_phase($urandom_range(0, 3), 2047, 110);
      else if (ph == 6) run_phase(MODE_BOTH, 2, 110);
      else run_phase($urandom_range(0, 3), $urandom_range(1, 64), 120);
    end

    wait (recv_count == sent_count);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/dovr_pkg.sv
src/dovr_in_if.sv
src/dovr_out_if.sv
src/dovr_cfg_if.sv
src/dovr_ram.sv
src/degree_ordered_vertex_relabel.sv
bench/dovr_relabel_checker.sv
bench/tb_degree_ordered_vertex_relabel.sv
